FILE: sv/gse_pkg.sv
// shared constants for the blur and edge magnitude block
package gse_pkg;

  localparam int unsigned CFG_W     = 11;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned EDGE_W    = 11;
  localparam int unsigned MIN_SIZE  = 5;
  localparam int unsigned MAX_HGT   = 1024;
  localparam int unsigned W_RESET   = 640;
  localparam int unsigned H_RESET   = 480;
  localparam int unsigned TOTAL_W   = 21;
  localparam int unsigned T_W       = 22;
  localparam int unsigned SQ_W      = 21;
  localparam int unsigned ROOT_STEPS = 11;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  // 1 4 6 4 1 weighted sum of five values, max 16 * 255
  function automatic logic [11:0] binom5(input logic [11:0] a, input logic [11:0] b,
                                         input logic [11:0] c, input logic [11:0] d,
                                         input logic [11:0] e);
    logic [15:0] s;
    begin
      s = 16'(a) + 16'(e) + (16'(b) << 2) + (16'(d) << 2) + (16'(c) << 2) + (16'(c) << 1);
      binom5 = s[11:0];
    end
  endfunction

  function automatic logic [15:0] binom5w(input logic [11:0] a, input logic [11:0] b,
                                          input logic [11:0] c, input logic [11:0] d,
                                          input logic [11:0] e);
    begin
      binom5w = 16'(a) + 16'(e) + (16'(b) << 2) + (16'(d) << 2) + (16'(c) << 2)
              + (16'(c) << 1);
    end
  endfunction

endpackage

FILE: sv/gauss5_sobel_edge_magnitude_top.sv
// top level: 5x5 binomial blur, sobel gradient and integer magnitude on a pixel stream
//
//  channel | ports                                   | direction
//  input   | in_valid in_ready in_op in_pixel        | in
//  result  | out_valid out_ready out_edge_res        | out
//          | out_frame_last                          |
//  config  | cfg_we cfg_index cfg_data               | in
//
// one item at a time: each pixel item passes line store read and write-back,
// two blur adder stages, gradient, squares, then an 11-step square root,
// one result bit per cycle. an ignored drain is taken in idle and starts nothing.
// synchronous active-low reset clears control; line stores are not cleared.
// a waiting result does not stop the next item until its result is ready.
module gauss5_sobel_edge_magnitude_top #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_op,
  input  logic [gse_pkg::PIX_W-1:0] in_pixel,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [gse_pkg::EDGE_W-1:0] out_edge_res,
  output logic                      out_frame_last,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [gse_pkg::CFG_W-1:0] cfg_data
);

  localparam int unsigned ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CW = gse_pkg::CFG_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_VSUM, S_HSUM, S_EDGE, S_GRAD, S_SQR, S_ROOT, S_DONE
  } state_t;

  state_t state_r;

  logic [CW-1:0] width_r, height_r;
  logic [gse_pkg::T_W-1:0] t_r;
  logic [gse_pkg::TOTAL_W-1:0] out_cnt_r;
  logic [CW-1:0] in_row_r, in_col_r, b_row_r, b_col_r;

  logic pix_phase_r, edge_act_r, produce_r, last_r;
  gse_pkg::pix_t px_r, bv_r;

  logic [31:0] in_mem [MAX_WIDTH];
  logic [15:0] blur_mem [MAX_WIDTH];
  logic [31:0] in_rd_r;
  logic [15:0] blur_rd_r;

  gse_pkg::pix_t win_r [5][5];
  gse_pkg::pix_t bwin_r [3][3];
  logic [11:0] vsum_r [5];

  logic signed [10:0] gx_r, gy_r;
  logic [gse_pkg::SQ_W-1:0] rem_r, root_r, bit_r;
  logic [3:0] step_r;

  logic [gse_pkg::EDGE_W-1:0] out_res_r;
  logic out_valid_r, out_last_r;

  // derived frame sizes
  logic [gse_pkg::TOTAL_W-1:0] total;
  logic [gse_pkg::T_W-1:0] thr_edge, thr_out;
  assign total    = gse_pkg::TOTAL_W'(width_r * height_r);
  assign thr_edge = gse_pkg::T_W'({width_r, 1'b0}) + gse_pkg::T_W'(2);
  assign thr_out  = gse_pkg::T_W'({width_r, 1'b0}) + gse_pkg::T_W'(width_r) + gse_pkg::T_W'(3);

  logic pix_phase_now, accept, ignore;
  assign pix_phase_now = t_r < gse_pkg::T_W'(total);
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign ignore   = (in_op == gse_pkg::OP_DRAIN) && pix_phase_now;

  logic [ADDR_W-1:0] in_addr, b_addr;
  assign in_addr = ADDR_W'(in_col_r);
  assign b_addr  = ADDR_W'(b_col_r);

  logic out_slot;
  assign out_slot = !out_valid_r || out_ready;

  // clamp a config value to [MIN_SIZE, hi]
  function automatic logic [CW-1:0] clamp_size(input logic [CW-1:0] v, input int unsigned hi);
    begin
      if (32'(v) < gse_pkg::MIN_SIZE) clamp_size = CW'(gse_pkg::MIN_SIZE);
      else if (32'(v) > hi) clamp_size = CW'(hi);
      else clamp_size = v;
    end
  endfunction

  // blur sum over the vertical partial sums
  logic [15:0] hsum;
  assign hsum = gse_pkg::binom5w(vsum_r[0], vsum_r[1], vsum_r[2], vsum_r[3], vsum_r[4]);

  logic blur_ok;
  assign blur_ok = pix_phase_r && (in_row_r >= CW'(4)) && (in_col_r >= CW'(4));

  logic edge_zero;
  assign edge_zero = !edge_act_r || (b_row_r < CW'(2)) || (b_row_r > height_r - CW'(1))
                   || (b_col_r < CW'(2));

  logic signed [10:0] gx, gy;
  always_comb begin
    gx = (11'(bwin_r[0][2]) + (11'(bwin_r[1][2]) << 1) + 11'(bwin_r[2][2]))
       - (11'(bwin_r[0][0]) + (11'(bwin_r[1][0]) << 1) + 11'(bwin_r[2][0]));
    gy = (11'(bwin_r[2][0]) + (11'(bwin_r[2][1]) << 1) + 11'(bwin_r[2][2]))
       - (11'(bwin_r[0][0]) + (11'(bwin_r[0][1]) << 1) + 11'(bwin_r[0][2]));
  end

  logic [9:0] ax, ay;
  assign ax = gx_r[10] ? 10'(-gx_r) : gx_r[9:0];
  assign ay = gy_r[10] ? 10'(-gy_r) : gy_r[9:0];

  logic [gse_pkg::SQ_W:0] trial;
  assign trial = (gse_pkg::SQ_W+1)'(root_r) + (gse_pkg::SQ_W+1)'(bit_r);

  // line stores: one column word holds all stored rows
  always_ff @(posedge clk) begin
    if (accept) begin
      in_rd_r   <= in_mem[in_addr];
      blur_rd_r <= blur_mem[b_addr];
    end
    if (state_r == S_LOAD) begin
      in_mem[in_addr] <= {in_rd_r[23:0], px_r};
    end
    if (state_r == S_EDGE && edge_act_r) begin
      blur_mem[b_addr] <= {blur_rd_r[7:0], bv_r};
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= (pix_phase_now && in_op == gse_pkg::OP_PIXEL) ? in_pixel : '0;
    end
    if (state_r == S_VSUM) begin
      for (int c = 0; c < 5; c++) begin
        vsum_r[c] <= gse_pkg::binom5(12'(win_r[0][c]), 12'(win_r[1][c]), 12'(win_r[2][c]),
                                     12'(win_r[3][c]), 12'(win_r[4][c]));
      end
    end
    if (state_r == S_HSUM) begin
      bv_r <= blur_ok ? hsum[15:8] : '0;
    end
    if (state_r == S_GRAD) begin
      gx_r <= edge_zero ? '0 : gx;
      gy_r <= edge_zero ? '0 : gy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= CW'(gse_pkg::W_RESET);
      height_r    <= CW'(gse_pkg::H_RESET);
      t_r         <= '0;
      out_cnt_r   <= '0;
      in_row_r    <= '0;
      in_col_r    <= '0;
      b_row_r     <= '0;
      b_col_r     <= '0;
      out_valid_r <= 1'b0;
      pix_phase_r <= 1'b0;
      edge_act_r  <= 1'b0;
      produce_r   <= 1'b0;
      last_r      <= 1'b0;
      step_r      <= '0;
      for (int r = 0; r < 5; r++) for (int c = 0; c < 5; c++) win_r[r][c] <= '0;
      for (int r = 0; r < 3; r++) for (int c = 0; c < 3; c++) bwin_r[r][c] <= '0;
    end else begin
      if (out_valid_r && out_ready && !(state_r == S_DONE && produce_r)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          gse_pkg::CFG_IDX_WIDTH:  width_r  <= clamp_size(cfg_data, MAX_WIDTH);
          gse_pkg::CFG_IDX_HEIGHT: height_r <= clamp_size(cfg_data, gse_pkg::MAX_HGT);
          default: ;
        endcase
        t_r       <= '0;
        out_cnt_r <= '0;
        in_row_r  <= '0;
        in_col_r  <= '0;
        b_row_r   <= '0;
        b_col_r   <= '0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept && !ignore) begin
            pix_phase_r <= pix_phase_now;
            edge_act_r  <= t_r >= thr_edge;
            produce_r   <= t_r >= thr_out;
            last_r      <= out_cnt_r == total - gse_pkg::TOTAL_W'(1);
            state_r     <= S_LOAD;
          end
        end
        S_LOAD: begin
          for (int r = 0; r < 5; r++) for (int c = 0; c < 4; c++) win_r[r][c] <= win_r[r][c+1];
          win_r[0][4] <= in_rd_r[31:24];
          win_r[1][4] <= in_rd_r[23:16];
          win_r[2][4] <= in_rd_r[15:8];
          win_r[3][4] <= in_rd_r[7:0];
          win_r[4][4] <= px_r;
          state_r <= S_VSUM;
        end
        S_VSUM: state_r <= S_HSUM;
        S_HSUM: state_r <= S_EDGE;
        S_EDGE: begin
          if (edge_act_r) begin
            for (int r = 0; r < 3; r++) for (int c = 0; c < 2; c++) begin
              bwin_r[r][c] <= bwin_r[r][c+1];
            end
            bwin_r[0][2] <= blur_rd_r[15:8];
            bwin_r[1][2] <= blur_rd_r[7:0];
            bwin_r[2][2] <= bv_r;
          end
          state_r <= S_GRAD;
        end
        S_GRAD: state_r <= S_SQR;
        S_SQR: begin
          rem_r   <= gse_pkg::SQ_W'(20'(ax * ax)) + gse_pkg::SQ_W'(20'(ay * ay));
          root_r  <= '0;
          bit_r   <= gse_pkg::SQ_W'(1) << (2 * (gse_pkg::ROOT_STEPS - 1));
          step_r  <= '0;
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          // one result bit per cycle, restoring square root
          if (gse_pkg::SQ_W'(trial) <= rem_r && !trial[gse_pkg::SQ_W]) begin
            rem_r  <= rem_r - gse_pkg::SQ_W'(trial);
            root_r <= (root_r >> 1) + bit_r;
          end else begin
            root_r <= root_r >> 1;
          end
          bit_r  <= bit_r >> 2;
          step_r <= step_r + 4'd1;
          if (step_r == 4'(gse_pkg::ROOT_STEPS - 1)) state_r <= S_DONE;
        end
        S_DONE: begin
          if (!produce_r || out_slot) begin
            state_r <= S_IDLE;
            if (produce_r && last_r) begin
              t_r       <= '0;
              out_cnt_r <= '0;
              in_row_r  <= '0;
              in_col_r  <= '0;
              b_row_r   <= '0;
              b_col_r   <= '0;
            end else begin
              t_r <= t_r + gse_pkg::T_W'(1);
              if (in_col_r == width_r - CW'(1)) begin
                in_col_r <= '0;
                in_row_r <= in_row_r + CW'(1);
              end else begin
                in_col_r <= in_col_r + CW'(1);
              end
              if (edge_act_r) begin
                if (b_col_r == width_r - CW'(1)) begin
                  b_col_r <= '0;
                  b_row_r <= b_row_r + CW'(1);
                end else begin
                  b_col_r <= b_col_r + CW'(1);
                end
              end
              if (produce_r) out_cnt_r <= out_cnt_r + gse_pkg::TOTAL_W'(1);
            end
            if (produce_r) begin
              out_valid_r <= 1'b1;
              out_res_r   <= gse_pkg::EDGE_W'(root_r);
              out_last_r  <= last_r;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_edge_res   = out_res_r;
  assign out_frame_last = out_last_r;

`ifndef ASSERT_OFF
  // a frame ends cleanly: counters restart after the last result is loaded
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && produce_r && out_slot && last_r && !cfg_we) |=>
      (t_r == '0 && out_cnt_r == '0))
    else $error("counters not cleared after frame end");

  // result count never reaches the frame size
  a_out_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_cnt_r < total)
    else $error("output count beyond frame");

  // root iteration keeps a single trial bit
  a_root_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT) |-> $onehot(bit_r))
    else $error("square root trial bit lost");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && state_r == S_DONE && produce_r) |=> $stable(out_res_r))
    else $error("pending result overwritten");
`endif

endmodule
